// ===== sv/drfd_pkg.sv =====
`timescale 1ns / 1ps
// drfd_pkg: shared constants and item types of the dicom rle fragment decoder
// used by drfd_out_fifo and dicom_rle_fragment_decoder_top; no dependencies
package drfd_pkg;

  localparam int unsigned MAX_SEGMENTS = 4;
  localparam int unsigned ADDRESS_BITS = 24;

  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned HDR_POS_W    = $clog2(HEADER_BYTES);
  localparam int unsigned SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned STEP_W       = 3;

  // packbits code points
  localparam logic [7:0] LIT_MAX_CODE     = 8'd127;
  localparam logic [7:0] REPEAT_SKIP_CODE = 8'd128;
  localparam logic [8:0] REPEAT_BASE      = 9'd257;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_fragment;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              byte_value;
    logic [ADDRESS_BITS-1:0] first_address;
    logic [7:0]              run_length;
    logic [STEP_W-1:0]       address_step;
    logic                    error_flag;
  } out_item_t;

endpackage

// ===== sv/dicom_rle_fragment_decoder_top.sv =====
`timescale 1ns / 1ps
// dicom_rle_fragment_decoder_top: header parse and packbits run decode of one rle fragment
// depends on drfd_pkg and drfd_out_fifo
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (byte, last flag)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (run descriptor)
//
// one byte item per cycle while in_stall_o is low; a run descriptor enters the result
// queue when its byte is taken. all decode state updates in the cycle of acceptance, so
// the per-byte rate is set by the state update path (offset subtract, segment select).
// reset clears the result queue and all decode state bar the offset and length stores;
// no clearing pass is needed. in_stall_o rises only when the two-entry queue is full.
module dicom_rle_fragment_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  drfd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drfd_pkg::out_item_t out_item_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUN,
    PH_VALUE,
    PH_IDLE
  } phase_e;

  localparam int unsigned K_W = drfd_pkg::HDR_POS_W - 2;
  localparam int unsigned AB  = drfd_pkg::ADDRESS_BITS;
  localparam int unsigned OW  = drfd_pkg::OFFSET_W;

  phase_e                             phase_q, phase_d;
  logic [drfd_pkg::HDR_POS_W-1:0]     pos_q, pos_d;
  logic [OW-9:0]                      hw_q, hw_d;
  logic [drfd_pkg::SEG_CNT_W-1:0]     seg_total_q, seg_total_d;
  logic [drfd_pkg::SEG_IDX_W-1:0]     cur_seg_q, cur_seg_d;
  logic [OW-1:0]                      left_q, left_d;
  logic [7:0]                         lit_q, lit_d;
  logic [AB-1:0]                      addr_q, addr_d;
  logic [OW-1:0]                      prev_off_q, prev_off_d;
  logic [OW-1:0]                      seg_len_q [drfd_pkg::MAX_SEGMENTS];
  logic [OW-1:0]                      seg_len_d [drfd_pkg::MAX_SEGMENTS];
  logic [drfd_pkg::MAX_SEGMENTS-1:0]  seg_ne_q, seg_ne_d;

  logic                               accept;
  logic                               fifo_full;
  logic [7:0]                         din;
  logic [1:0]                         sub;
  logic [K_W-1:0]                     k;
  logic                               k_ok;
  logic [OW-1:0]                      word;
  logic [OW:0]                        diff;

  logic [drfd_pkg::SEG_CNT_W-1:0]     bs_start;
  logic                               bs_found;
  logic [drfd_pkg::SEG_IDX_W-1:0]     bs_seg;
  logic [OW-1:0]                      bs_left;

  logic                               res_valid;
  drfd_pkg::out_item_t                res;
  logic                               run_emit;
  logic [7:0]                         run_len;
  logic [10:0]                        run_span;
  logic                               seg_enter;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = fifo_full;
  assign din        = in_item_i.data_byte;
  assign sub        = pos_q[1:0];
  assign k          = pos_q[drfd_pkg::HDR_POS_W-1:2] - K_W'(1);
  assign k_ok       = (32'(k) < 32'(seg_total_q)) && (32'(k) < drfd_pkg::MAX_SEGMENTS);
  assign word       = {din, hw_q};
  assign diff       = {1'b0, word} - {1'b0, prev_off_q};

  // offset store: each new offset turns into the length of the segment before it
  always_comb begin
    hw_d       = hw_q;
    prev_off_d = prev_off_q;
    seg_len_d  = seg_len_q;
    seg_ne_d   = seg_ne_q;
    if (accept && phase_q == PH_HEADER) begin
      if (pos_q[drfd_pkg::HDR_POS_W-1:2] == '0 || k_ok) begin
        case (sub)
          2'd0:    hw_d[7:0]   = din;
          2'd1:    hw_d[15:8]  = din;
          2'd2:    hw_d[23:16] = din;
          default: hw_d        = '0;
        endcase
      end
      if (pos_q[drfd_pkg::HDR_POS_W-1:2] != '0 && k_ok && sub == 2'd3) begin
        prev_off_d = word;
        if (k != '0) begin
          seg_len_d[drfd_pkg::SEG_IDX_W'(k - K_W'(1))] = diff[OW-1:0];
          seg_ne_d[drfd_pkg::SEG_IDX_W'(k - K_W'(1))]  = !diff[OW] && (diff[OW-1:0] != '0);
        end
      end
    end
    if (accept && in_item_i.last_of_fragment) begin
      hw_d = '0;
    end
  end

  // next segment to enter: first from bs_start that is the last one or not empty
  assign bs_start = (phase_q == PH_HEADER) ? '0
                  : drfd_pkg::SEG_CNT_W'(cur_seg_q) + drfd_pkg::SEG_CNT_W'(1);

  always_comb begin
    bs_found = 1'b0;
    bs_seg   = '0;
    bs_left  = '0;
    for (int i = 0; i < int'(drfd_pkg::MAX_SEGMENTS); i++) begin
      if (!bs_found && 32'(i) >= 32'(bs_start) && 32'(i) < 32'(seg_total_q)) begin
        if (32'(i) + 32'd1 == 32'(seg_total_q)) begin
          bs_found = 1'b1;
          bs_seg   = drfd_pkg::SEG_IDX_W'(i);
          bs_left  = '0;
        end else if (seg_ne_d[i]) begin
          bs_found = 1'b1;
          bs_seg   = drfd_pkg::SEG_IDX_W'(i);
          bs_left  = seg_len_d[i];
        end
      end
    end
  end

  assign run_span = 11'(run_len) * 11'(seg_total_q);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    seg_total_d = seg_total_q;
    cur_seg_d   = cur_seg_q;
    left_d      = left_q;
    lit_d       = lit_q;
    addr_d      = addr_q;
    res_valid   = 1'b0;
    res         = '0;
    run_emit    = 1'b0;
    run_len     = '0;
    seg_enter   = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (pos_q[drfd_pkg::HDR_POS_W-1:2] == '0 && sub == 2'd3 &&
              word > OW'(drfd_pkg::MAX_SEGMENTS)) begin
            res_valid     = 1'b1;
            res.error_flag = 1'b1;
            phase_d       = PH_IDLE;
          end else begin
            if (pos_q[drfd_pkg::HDR_POS_W-1:2] == '0 && sub == 2'd3) begin
              seg_total_d = drfd_pkg::SEG_CNT_W'(word);
            end
            pos_d = pos_q + 1'b1;
            if (pos_q == drfd_pkg::HDR_POS_W'(drfd_pkg::HEADER_BYTES - 1)) begin
              seg_enter = 1'b1;
            end
          end
        end
        PH_RUN, PH_VALUE: begin
          if (phase_q == PH_VALUE) begin
            run_emit = 1'b1;
            run_len  = lit_q;
            lit_d    = '0;
            phase_d  = PH_RUN;
          end else if (lit_q != '0) begin
            run_emit = 1'b1;
            run_len  = 8'd1;
            lit_d    = lit_q - 8'd1;
          end else if (din <= drfd_pkg::LIT_MAX_CODE) begin
            lit_d = din + 8'd1;
          end else if (din != drfd_pkg::REPEAT_SKIP_CODE) begin
            lit_d   = 8'(drfd_pkg::REPEAT_BASE - {1'b0, din});
            phase_d = PH_VALUE;
          end
          // the last segment runs to the end of the fragment
          if (32'(cur_seg_q) + 32'd1 < 32'(seg_total_q)) begin
            if (left_q != '0) begin
              left_d = left_q - OW'(1);
            end
            if (left_q <= OW'(1)) begin
              seg_enter = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (run_emit) begin
        res_valid         = 1'b1;
        res.byte_value    = din;
        res.first_address = addr_q;
        res.run_length    = run_len;
        res.address_step  = drfd_pkg::STEP_W'(seg_total_q);
        addr_d            = addr_q + AB'(run_span);
      end

      if (seg_enter) begin
        if (bs_found) begin
          cur_seg_d = bs_seg;
          addr_d    = AB'(bs_seg);
          lit_d     = '0;
          phase_d   = PH_RUN;
          left_d    = bs_left;
        end else begin
          phase_d = PH_IDLE;
        end
      end

      if (in_item_i.last_of_fragment) begin
        phase_d     = PH_HEADER;
        pos_d       = '0;
        seg_total_d = '0;
        cur_seg_d   = '0;
        left_d      = '0;
        lit_d       = '0;
        addr_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      hw_q        <= '0;
      seg_total_q <= '0;
      cur_seg_q   <= '0;
      left_q      <= '0;
      lit_q       <= '0;
      addr_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      hw_q        <= hw_d;
      seg_total_q <= seg_total_d;
      cur_seg_q   <= cur_seg_d;
      left_q      <= left_d;
      lit_q       <= lit_d;
      addr_q      <= addr_d;
    end
  end

  // offsets and lengths are read only after this fragment's header wrote them
  always_ff @(posedge clk_i) begin
    prev_off_q <= prev_off_d;
    seg_len_q  <= seg_len_d;
    seg_ne_q   <= seg_ne_d;
  end

  drfd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (res),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_err_from_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.error_flag) |-> phase_q == PH_HEADER)
    else $error("segment count error outside header");

  a_run_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.error_flag) |->
      (res.run_length != '0) && (phase_q == PH_RUN || phase_q == PH_VALUE))
    else $error("run item with bad length or phase");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(seg_total_q) <= drfd_pkg::MAX_SEGMENTS)
    else $error("segment count above limit");

  a_value_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_VALUE |-> lit_q != '0)
    else $error("repeat pending with zero length");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_of_fragment) |=> (phase_q == PH_HEADER && pos_q == '0))
    else $error("decoder did not restart after final item");

endmodule

// ===== sv/drfd_out_fifo.sv =====
`timescale 1ns / 1ps
// drfd_out_fifo: small result queue that decouples the decoder from output stalls
// depends on drfd_pkg for the result item type and queue depth
module drfd_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  drfd_pkg::out_item_t push_item_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drfd_pkg::out_item_t out_item_o
);

  drfd_pkg::out_item_t                   mem_q [drfd_pkg::FIFO_DEPTH];
  logic [drfd_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [drfd_pkg::FIFO_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [drfd_pkg::FIFO_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign full_o      = (cnt_q == drfd_pkg::FIFO_CNT_W'(drfd_pkg::FIFO_DEPTH));
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("result pushed into full queue");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= drfd_pkg::FIFO_CNT_W'(drfd_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_cnt_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("result queue count did not advance on push");

endmodule

// ===== sim/drfd_run_checker.sv =====
`timescale 1ns / 1ps
// drfd_run_checker: watches both channels of the rle fragment decoder, predicts the
// run descriptors of every accepted byte and compares them in order; uses drfd_pkg
module drfd_run_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  drfd_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  drfd_pkg::out_item_t out_item_i,
  output int                  runs_pending_o,
  output int                  mismatch_count_o
);
  import drfd_pkg::*;

  typedef enum logic [1:0] {
    P_HEADER,
    P_CODE,
    P_REPEAT_VALUE,
    P_DONE
  } phase_e;

  // decoder image
  logic [31:0]             byte_pos;
  logic [31:0]             field_acc;
  int unsigned             seg_count;
  logic [31:0]             seg_offset [MAX_SEGMENTS];
  int unsigned             seg_idx;
  logic [31:0]             seg_remaining;
  phase_e                  phase;
  int unsigned             pending_len;
  logic [ADDRESS_BITS-1:0] next_addr;

  out_item_t expected_runs [$];
  int        mismatches;

  task automatic restart_fragment();
    byte_pos      = '0;
    field_acc     = '0;
    seg_count     = 0;
    seg_idx       = 0;
    seg_remaining = '0;
    phase         = P_HEADER;
    pending_len   = 0;
    next_addr     = '0;
  endtask

  // move to segment s, skipping segments with no bytes
  task automatic enter_segment(input int unsigned s);
    bit done;
    done = 1'b0;
    while (!done) begin
      if (s >= seg_count || s >= MAX_SEGMENTS) begin
        phase = P_DONE;
        done  = 1'b1;
      end else begin
        seg_idx       = s;
        next_addr     = ADDRESS_BITS'(s);
        pending_len   = 0;
        phase         = P_CODE;
        seg_remaining = '0;
        if (s + 1 == seg_count) begin
          done = 1'b1;
        end else if (seg_offset[s+1] > seg_offset[s]) begin
          seg_remaining = seg_offset[s+1] - seg_offset[s];
          done          = 1'b1;
        end else begin
          s++;
        end
      end
    end
  endtask

  task automatic push_run(input logic [7:0] value, input int unsigned len);
    out_item_t r;
    r.byte_value    = value;
    r.first_address = next_addr;
    r.run_length    = len[7:0];
    r.address_step  = seg_count[STEP_W-1:0];
    r.error_flag    = 1'b0;
    expected_runs.push_back(r);
    next_addr = next_addr + ADDRESS_BITS'(len * seg_count);
  endtask

  task automatic decode_byte(input in_item_t it);
    logic [7:0]  b;
    logic [31:0] pos;
    int unsigned k;
    int unsigned sub;
    out_item_t   err;
    b = it.data_byte;
    if (phase == P_HEADER) begin
      pos = byte_pos;
      if (pos < 4) begin
        field_acc = field_acc | (32'(b) << (8 * pos));
        if (pos == 3) begin
          if (field_acc > MAX_SEGMENTS) begin
            err            = '0;
            err.error_flag = 1'b1;
            expected_runs.push_back(err);
            phase = P_DONE;
          end else begin
            seg_count = field_acc;
          end
          field_acc = '0;
        end
      end else begin
        k   = (pos - 4) >> 2;
        sub = (pos - 4) & 3;
        if (k < seg_count && k < MAX_SEGMENTS) begin
          field_acc = field_acc | (32'(b) << (8 * sub));
          if (sub == 3) begin
            seg_offset[k] = field_acc;
            field_acc     = '0;
          end
        end
      end
      if (phase == P_HEADER) begin
        byte_pos = pos + 1;
        if (pos + 1 >= HEADER_BYTES) enter_segment(0);
      end
    end else if (phase == P_CODE || phase == P_REPEAT_VALUE) begin
      if (phase == P_REPEAT_VALUE) begin
        push_run(b, pending_len);
        pending_len = 0;
        phase       = P_CODE;
      end else if (pending_len > 0) begin
        push_run(b, 1);
        pending_len--;
      end else if (b <= LIT_MAX_CODE) begin
        pending_len = b + 1;
      end else if (b > REPEAT_SKIP_CODE) begin
        pending_len = REPEAT_BASE - b;
        phase       = P_REPEAT_VALUE;
      end
      // the last segment runs to the end of the fragment
      if (seg_idx + 1 < seg_count) begin
        if (seg_remaining > 0) seg_remaining--;
        if (seg_remaining == 0) enter_segment(seg_idx + 1);
      end
    end
    if (it.last_of_fragment) restart_fragment();
  endtask

  task automatic check_run(input out_item_t got);
    out_item_t want;
    if (expected_runs.size() == 0) begin
      if (mismatches < 10)
        $display("%0t unexpected run: val %h addr %h len %0d step %0d err %b", $realtime,
                 got.byte_value, got.first_address, got.run_length, got.address_step,
                 got.error_flag);
      mismatches++;
    end else begin
      want = expected_runs.pop_front();
      if (got.byte_value !== want.byte_value || got.first_address !== want.first_address ||
          got.run_length !== want.run_length || got.address_step !== want.address_step ||
          got.error_flag !== want.error_flag) begin
        if (mismatches < 10) begin
          $display("%0t run mismatch", $realtime);
          $display("  expected val %h addr %h len %0d step %0d err %b", want.byte_value,
                   want.first_address, want.run_length, want.address_step, want.error_flag);
          $display("  actual   val %h addr %h len %0d step %0d err %b", got.byte_value,
                   got.first_address, got.run_length, got.address_step, got.error_flag);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_fragment();
      for (int i = 0; i < MAX_SEGMENTS; i++) seg_offset[i] = '0;
      expected_runs.delete();
      mismatches = 0;
      runs_pending_o   <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(in_item_i);
      if (out_valid_i && !out_stall_i) check_run(out_item_i);
      runs_pending_o   <= expected_runs.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== sim/tb_dicom_rle_fragment_decoder_top.sv =====
`timescale 1ns / 1ps
// tb_dicom_rle_fragment_decoder_top: builds rle fragments (headers, packbits segments,
// broken and cut fragments) and drives them into the decoder; depends on drfd_pkg,
// drfd_run_checker and dicom_rle_fragment_decoder_top
module tb_dicom_rle_fragment_decoder_top;
  import drfd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEM_TARGET  = 1000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        runs_pending;
  int        mismatch_count;
  bit        hold_req;
  int        cycle_count;
  int        items_sent;

  logic [7:0] frag_q [$];
  logic [7:0] data_q [$];

  dicom_rle_fragment_decoder_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  drfd_run_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_i      (out_item),
    .runs_pending_o  (runs_pending),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_dicom_rle_fragment_decoder_top NOT OK");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    bit   hold_done;
    int   r;
    int   len;
    logic lvl;
    hold_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 19);
        if (r < 9) begin
          lvl = 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 16) begin
          lvl = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 18) begin
          lvl = 1'b1;
          len = $urandom_range(15, 60);
        end else begin
          lvl = 1'b0;
          len = $urandom_range(80, 200);
        end
        out_stall <= lvl;
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit gapless);
    in_item_t it;
    int       gap;
    int       r;
    gap = 0;
    if (!gapless) begin
      r = $urandom_range(0, 19);
      if (r >= 18) gap = $urandom_range(10, 40);
      else if (r >= 11) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte        = b;
    it.last_of_fragment = last;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // cut > 0 ends the fragment early at that byte
  task automatic send_fragment(input int cut, input bit gapless);
    int n;
    n = (cut > 0 && cut < frag_q.size()) ? cut : frag_q.size();
    for (int i = 0; i < n; i++) send_byte(frag_q[i], i == n - 1, gapless);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (runs_pending != 0);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) frag_q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_header(input logic [31:0] count, input logic [127:0] offs);
    put_word(count);
    for (int s = 0; s < MAX_SEGMENTS && s < count; s++) put_word(offs[32*s +: 32]);
    while (frag_q.size() < HEADER_BYTES) frag_q.push_back(8'($urandom));
  endtask

  // bytes listed left to right
  task automatic put_seq(input logic [127:0] seq, input int n);
    for (int i = 0; i < n; i++) frag_q.push_back(seq[8*(n-1-i) +: 8]);
  endtask

  // packbits packets of about target bytes; trim cuts the last packet at the target
  task automatic put_packets(input int target, input bit trim);
    int start;
    int r;
    int n;
    start = data_q.size();
    while (data_q.size() - start < target) begin
      r = $urandom_range(0, 19);
      if (r < 9) begin
        n = (r == 0) ? $urandom_range(0, LIT_MAX_CODE) : $urandom_range(0, 5);
        data_q.push_back(8'(n));
        repeat (n + 1) data_q.push_back(8'($urandom));
      end else if (r < 18) begin
        data_q.push_back(8'($urandom_range(REPEAT_SKIP_CODE + 1, 255)));
        data_q.push_back(8'($urandom));
      end else begin
        data_q.push_back(REPEAT_SKIP_CODE);
      end
    end
    if (trim)
      while (data_q.size() - start > target) data_q.delete(data_q.size() - 1);
  endtask

  task automatic random_fragment();
    logic [31:0]  count;
    logic [31:0]  off;
    logic [127:0] offs;
    int           seg_len [MAX_SEGMENTS];
    int           start;
    int           r;
    int           cut;
    bit           messy;
    bit           gapless;
    frag_q.delete();
    data_q.delete();
    gapless = ($urandom_range(0, 5) == 0);
    r = $urandom_range(0, 29);
    if (r == 0) count = 0;
    else if (r == 1) count = $urandom_range(MAX_SEGMENTS + 1, 255);
    else if (r == 2) begin
      count = $urandom;
      if (count <= MAX_SEGMENTS) count = 32'hFFFF_FFFF;
    end else count = $urandom_range(1, MAX_SEGMENTS);
    if (count > MAX_SEGMENTS) begin
      // bad segment count, the rest of the fragment is dropped
      put_word(count);
      repeat ($urandom_range(0, 70)) frag_q.push_back(8'($urandom));
      send_fragment(0, gapless);
    end else begin
      for (int s = 0; s < count; s++) begin
        start = data_q.size();
        r = $urandom_range(0, 19);
        put_packets((r == 0) ? 0 : (r == 1) ? $urandom_range(60, 150) : $urandom_range(1, 24),
                    $urandom_range(0, 3) == 0);
        seg_len[s] = data_q.size() - start;
      end
      if (count == 0) repeat ($urandom_range(1, 8)) data_q.push_back(8'($urandom));
      messy = ($urandom_range(0, 9) == 0);
      offs  = '0;
      off   = messy ? 32'($urandom) : 32'(HEADER_BYTES);
      for (int s = 0; s < count; s++) begin
        offs[32*s +: 32] = (messy && $urandom_range(0, 2) == 0) ? 32'($urandom) : off;
        off = off + seg_len[s];
      end
      put_header(count, offs);
      foreach (data_q[i]) frag_q.push_back(data_q[i]);
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, frag_q.size()) : 0;
      send_fragment(cut, gapless);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // literal code 0, longest and shortest repeat, skip code, values 00 and ff
    frag_q.delete();
    put_header(1, 128'd64);
    put_seq(80'h00AA_8155_80FF_0001_FF00, 10);
    send_fragment(0, 1'b0);
    // too many segments, then a count with the top byte set above a low byte of 2
    frag_q.delete();
    put_word(32'd5);
    repeat (6) frag_q.push_back(8'($urandom));
    send_fragment(0, 1'b0);
    frag_q.delete();
    put_word(32'hFF00_0002);
    frag_q.push_back(8'h00);
    send_fragment(0, 1'b0);
    // no segments
    frag_q.delete();
    put_header(0, '0);
    put_seq(24'h05_8147, 3);
    send_fragment(0, 1'b0);
    // literal cut by segment end, empty and negative segments skipped
    frag_q.delete();
    put_header(4, {32'd60, 32'd67, 32'd67, 32'd64});
    put_seq(56'h0211_2283_4400_5A, 7);
    send_fragment(0, 1'b0);
    // repeat losing its value byte at segment end, fragment ending in a literal
    frag_q.delete();
    put_header(2, {32'd0, 32'd0, 32'd67, 32'd64});
    put_seq(64'h0033_FDFE_7705_0102, 8);
    send_fragment(0, 1'b0);
    // fragments ending in the header padding after the offsets and inside the count
    frag_q.delete();
    put_header(3, {32'd0, 32'd90, 32'd80, 32'd64});
    send_fragment(20, 1'b0);
    frag_q.delete();
    put_header(1, 128'd64);
    send_fragment(2, 1'b0);
    // fragment ending on a repeat code
    frag_q.delete();
    put_header(1, 128'd64);
    put_seq(24'h0001_C0, 3);
    send_fragment(0, 1'b0);
    wait_drained();

    // back-to-back literals while the receiver holds off
    hold_req = 1'b1;
    frag_q.delete();
    put_header(1, 128'd64);
    frag_q.push_back(8'd39);
    repeat (40) frag_q.push_back(8'($urandom));
    send_fragment(0, 1'b1);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      random_fragment();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && runs_pending == 0)
      $display("tb_dicom_rle_fragment_decoder_top OK");
    else
      $display("tb_dicom_rle_fragment_decoder_top NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/drfd_pkg.sv
sv/drfd_out_fifo.sv
sv/dicom_rle_fragment_decoder_top.sv
sim/drfd_run_checker.sv
sim/tb_dicom_rle_fragment_decoder_top.sv
